[hdl/spi_pkg.sv]
// Shared types and constants for the spectral peak interpolator.
// No dependencies; used by every module under hdl.
package spi_pkg;

  localparam int MagW = 33;
  localparam int SpW  = 24;
  localparam int ThW  = 33;
  localparam int FrqW = 24;
  localparam int CfgW = 33;

  localparam logic CFG_SPACING   = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  localparam logic [SpW-1:0] SPACING_RST   = 24'd88064;
  localparam logic [ThW-1:0] THRESHOLD_RST = 33'd8388608;

  // Frame summary handed from the tracker to the interpolation engine.
  typedef struct packed {
    logic           found;
    logic           edge_pk;
    logic [MagW-1:0] y0;
    logic [MagW-1:0] y1;
    logic [MagW-1:0] y2;
    logic [15:0]    k;
  } frame_t;

  typedef struct packed {
    logic            found;
    logic            edge_pk;
    logic [FrqW-1:0] freq;
    logic [MagW-1:0] level;
  } result_t;

endpackage

[hdl/spi_mag.sv]
// Bit-serial integer square root for one bin magnitude.
// Depends on spi_pkg.
module spi_mag import spi_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [31:0]     re,
  input  logic [31:0]     im,
  output logic            busy,
  output logic            done,
  output logic [MagW-1:0] mag
);

  logic [63:0] rad_r, rad_nxt;
  logic [65:0] rem_r, rem_nxt;
  logic [32:0] root_r, root_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] are, aim;
  logic [65:0] trial;
  logic [65:0] shifted;

  assign are = re[31] ? (~re + 32'd1) : re;
  assign aim = im[31] ? (~im + 32'd1) : im;
  assign shifted = {rem_r[63:0], rad_r[63:62]};
  assign trial = {31'd0, root_r, 2'b01};

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = {32'd0, are} * {32'd0, are} + {32'd0, aim} * {32'd0, aim};
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one result bit per cycle
      rad_nxt = {rad_r[61:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[31:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign mag  = root_r;

endmodule

[hdl/spi_track.sv]
// Front part: takes bins, computes magnitudes and tracks the frame peak.
// Depends on spi_pkg and spi_mag.
module spi_track import spi_pkg::*; #(
  parameter int MAX_BINS = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  logic [31:0]    re,
  input  logic [31:0]    im,
  input  logic           last,
  input  logic [ThW-1:0] threshold,
  output logic           frm_valid,
  input  logic           frm_ready,
  output frame_t         frm
);

  localparam int CntW = $clog2(MAX_BINS + 1);

  logic            mbusy, mdone;
  logic [MagW-1:0] mag;
  logic            last_r;
  logic            hold_r;
  frame_t          frm_r;
  logic [CntW-1:0] cnt_r;
  logic [MagW-1:0] max_r, left_r, right_r, prev_r;
  logic [CntW-1:0] idx_r;
  logic            pend_r;
  logic            accept;
  logic [CntW-1:0] last_idx;
  logic            track;

  assign full   = mbusy | mdone | hold_r;
  assign accept = push & ~full;

  spi_mag u_mag (
    .clk(clk), .rst_n(rst_n), .start(accept), .re(re), .im(im),
    .busy(mbusy), .done(mdone), .mag(mag)
  );

  assign track    = cnt_r < CntW'(MAX_BINS);
  assign last_idx = track ? cnt_r : CntW'(MAX_BINS - 1);

  always_ff @(posedge clk) begin
    if (accept) last_r <= last;
    if (!rst_n) begin
      cnt_r <= '0; max_r <= '0; idx_r <= '0; left_r <= '0;
      right_r <= '0; prev_r <= '0; pend_r <= 1'b0; hold_r <= 1'b0;
    end else begin
      if (hold_r && frm_ready) hold_r <= 1'b0;
      if (mdone) begin
        if (last_r) begin
          // close the frame; the tracking of this bin folds in below
          hold_r        <= 1'b1;
          cnt_r <= '0; max_r <= '0; idx_r <= '0; left_r <= '0;
          right_r <= '0; prev_r <= '0; pend_r <= 1'b0;
          begin
            logic [MagW-1:0] m0, l0, r0;
            logic [CntW-1:0] i0;
            m0 = max_r; l0 = left_r; r0 = right_r; i0 = idx_r;
            if (track) begin
              if (mag > max_r) begin
                m0 = mag; i0 = cnt_r; l0 = prev_r; r0 = '0;
              end else if (pend_r) begin
                r0 = mag;
              end
            end
            frm_r.found   <= m0 > threshold;
            frm_r.edge_pk <= (i0 == '0) || (i0 == last_idx);
            frm_r.y0      <= m0;
            frm_r.y1      <= l0;
            frm_r.y2      <= r0;
            frm_r.k       <= 16'(i0);
          end
        end else if (track) begin
          if (mag > max_r) begin
            max_r <= mag; idx_r <= cnt_r; left_r <= prev_r;
            right_r <= '0; pend_r <= 1'b1;
          end else if (pend_r) begin
            right_r <= mag; pend_r <= 1'b0;
          end
          prev_r <= mag;
          cnt_r  <= cnt_r + CntW'(1);
        end
      end
    end
  end

  assign frm_valid = hold_r;
  assign frm       = frm_r;

endmodule

[hdl/spi_interp.sv]
// Back part: parabolic fit over the three magnitudes with a serial divider.
// Depends on spi_pkg.
module spi_interp import spi_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           frm_valid,
  output logic           frm_ready,
  input  frame_t         frm,
  input  logic [SpW-1:0] spacing,
  output logic           res_valid,
  input  logic           res_ready,
  output result_t        res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]   st_r;
  frame_t       f_r;
  logic [34:0]  d_r;
  logic [32:0]  diff_r;
  logic         up_r, curv_r;
  logic [68:0]  rem_r;
  logic [68:0]  q_r;
  logic [6:0]   n_r;
  logic [37:0]  den_r;
  logic [47:0]  off_r;
  logic [31:0]  pos_r;
  logic [55:0]  prod_r;
  logic [1:0]   mph_r;
  logic [33:0]  lvl_r;
  logic [65:0]  sq;
  logic [69:0]  rsh;
  logic [31:0]  posn;
  result_t      res_r;

  assign rsh   = {rem_r, q_r[68]};
  assign frm_ready = (st_r == S_IDLE);

  always_comb begin
    if (up_r) posn = {f_r.k, 16'd0} + off_r[31:0];
    else if ({16'd0, f_r.k, 16'd0} > off_r) posn = {f_r.k, 16'd0} - off_r[31:0];
    else posn = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (st_r)
        S_IDLE: if (frm_valid) begin
          f_r  <= frm;
          n_r  <= '0;
          rem_r <= '0;
          begin
            logic [34:0] s2, s12;
            s2  = {1'b0, frm.y0, 1'b0};
            s12 = {2'b0, frm.y1} + {2'b0, frm.y2};
            curv_r <= s2 > s12;
            d_r    <= s2 - s12;
            up_r   <= frm.y2 >= frm.y1;
            diff_r <= (frm.y2 >= frm.y1) ? frm.y2 - frm.y1 : frm.y1 - frm.y2;
            q_r    <= {21'd0, ((frm.y2 >= frm.y1) ? frm.y2 - frm.y1
                                                   : frm.y1 - frm.y2), 15'd0};
            den_r  <= {3'd0, s2 - s12};
          end
          if (!frm.found || frm.edge_pk) st_r <= S_OUT;
          else st_r <= S_DIV1;
        end
        S_DIV1, S_DIV2: begin
          // restoring divide, one quotient bit per cycle
          if (!curv_r) begin
            off_r <= '0; lvl_r <= {1'b0, f_r.y0}; pos_r <= {f_r.k, 16'd0};
            st_r <= S_MUL; mph_r <= '0; prod_r <= '0;
          end else begin
            if (rsh >= {32'd0, den_r}) begin
              rem_r <= 69'(rsh - {32'd0, den_r});
              q_r   <= {q_r[67:0], 1'b1};
            end else begin
              rem_r <= rsh[68:0];
              q_r   <= {q_r[67:0], 1'b0};
            end
            n_r <= n_r + 7'd1;
            if (n_r == 7'd68) begin
              if (st_r == S_DIV1) st_r <= S_SQ;
              else st_r <= S_MUL;
            end
          end
        end
        S_SQ: begin
          off_r <= q_r[47:0];
          q_r   <= {3'd0, sq};
          rem_r <= '0;
          n_r   <= '0;
          mph_r <= '0;
          den_r <= {d_r, 3'd0};
          st_r  <= S_DIV2;
        end
        S_MUL: begin
          if (curv_r && mph_r == 2'd0) begin
            lvl_r  <= (q_r > 69'h1_FFFF_FFFF) ? 34'h3_FFFF_FFFF
                      : {1'b0, f_r.y0} + {1'b0, q_r[32:0]};
            pos_r  <= posn;
          end
          // two 16x24 partial products
          if (mph_r == 2'd1) prod_r <= {32'd0, spacing} * {40'd0, pos_r[15:0]};
          if (mph_r == 2'd2) begin
            prod_r <= prod_r + (({32'd0, spacing} * {40'd0, pos_r[31:16]}) << 16);
            st_r   <= S_OUT;
          end
          mph_r <= mph_r + 2'd1;
        end
        S_OUT: if (!res_valid) begin
          res_valid <= 1'b1;
          res_r.found   <= f_r.found;
          res_r.edge_pk <= f_r.found & f_r.edge_pk;
          if (!f_r.found || f_r.edge_pk) begin
            res_r.freq <= '0; res_r.level <= '0;
          end else begin
            res_r.freq  <= (prod_r[55:20] > 36'hFF_FFFF) ? 24'hFF_FFFF : prod_r[43:20];
            res_r.level <= lvl_r[33] ? 33'h1_FFFF_FFFF : lvl_r[32:0];
          end
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign sq  = {33'd0, diff_r} * {33'd0, diff_r};
  assign res = res_r;

endmodule

[hdl/spectral_peak_interpolator.sv]
// Spectral peak interpolator: streams complex FFT bins, one per transaction,
// and on the bin flagged last pushes one peak result. Each bin holds the input
// for the 32-step bit-serial square root of the magnitude unit plus its
// start and done cycles; the last bin of a frame also holds it until the frame
// is handed to the fit engine. The per-frame parabolic fit (two serial 69-step
// divides) overlaps the next frame; a frame that closes while the fit or a
// waiting result is busy stalls the input until it frees up.
// Config writes take effect on the next cycle; no reset clearing pass.
module spectral_peak_interpolator import spi_pkg::*; #(
  parameter int MAX_BINS = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic [31:0]     in_bin_real,
  input  logic [31:0]     in_bin_imag,
  input  logic            in_last_bin,
  output logic            empty,
  input  logic            pop,
  output logic            out_peak_found,
  output logic            out_peak_at_edge,
  output logic [FrqW-1:0] out_peak_freq,
  output logic [MagW-1:0] out_peak_level,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data
);

  logic [SpW-1:0] spacing_r;
  logic [ThW-1:0] thresh_r;
  logic           fv, fr, rv;
  frame_t         frm;
  result_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RST;
      thresh_r  <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPACING:   spacing_r <= cfg_data[SpW-1:0];
        CFG_THRESHOLD: thresh_r  <= cfg_data[ThW-1:0];
        default: ;
      endcase
    end
  end

  spi_track #(.MAX_BINS(MAX_BINS)) u_track (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .re(in_bin_real), .im(in_bin_imag), .last(in_last_bin),
    .threshold(thresh_r), .frm_valid(fv), .frm_ready(fr), .frm(frm)
  );

  spi_interp u_interp (
    .clk(clk), .rst_n(rst_n), .frm_valid(fv), .frm_ready(fr), .frm(frm),
    .spacing(spacing_r), .res_valid(rv), .res_ready(pop), .res(res)
  );

  assign empty            = ~rv;
  assign out_peak_found   = res.found;
  assign out_peak_at_edge = res.edge_pk;
  assign out_peak_freq    = res.freq;
  assign out_peak_level   = res.level;

endmodule
